[hdl/rrs_pkg.sv]
// Shared types and codes for the round-robin thread scheduler.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package rrs_pkg;

    // Request codes
    localparam logic [1:0] REQ_CREATE = 2'h0;
    localparam logic [1:0] REQ_YIELD  = 2'h1;
    localparam logic [1:0] REQ_EXIT   = 2'h2;

    // Slot state codes
    localparam logic [1:0] ST_FREE     = 2'h0;
    localparam logic [1:0] ST_RUNNING  = 2'h1;
    localparam logic [1:0] ST_RUNNABLE = 2'h2;

    localparam int ADDR_W = 39;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] entry_address;
    } req_word_t;

    typedef struct packed {
        logic [1:0]        slot;
        logic [1:0]        prev_slot;
        logic              switched;
        logic [ADDR_W-1:0] start_address;
        logic              table_full;
        logic              no_runnable;
    } rsp_word_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic step;
        logic push;
    } rrs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic direct;
        logic scan_done;
        logic out_busy;
    } rrs_status_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_PUSH = 3'b100
    } rrs_state_t;

endpackage

[hdl/round_robin_thread_scheduler.sv]
// Top level of the round-robin thread scheduler.
// Depends on rrs_pkg, rrs_ctrl and rrs_datapath.
`timescale 1ns / 1ps
//
// Channel   Signals                          Word type
// -------   ------------------------------   -------------------
// request   req_valid / req_ready / req_word rrs_pkg::req_word_t
// response  rsp_valid / rsp_ready / rsp_word rrs_pkg::rsp_word_t
//
// Create, yield and exit pass through the accept, scan and push states; the scan
// covers 1 to NUM_SLOTS slots and visits one slot of the slot-state table per
// cycle. Requests while halted, and unknown codes, go from accept straight to
// push and skip the scan.
// Reset (rst_n, asynchronous) leaves slot 0 running, others free, halt clear.
// A stalled response sits in the output register; the next request is taken
// and scanned meanwhile, and its result waits in the push stage.

module round_robin_thread_scheduler #(
    parameter int NUM_SLOTS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  rrs_pkg::req_word_t req_word,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rrs_pkg::rsp_word_t rsp_word
);

    // command and status between sequencer and datapath
    rrs_pkg::rrs_cmd_t    cmd;
    rrs_pkg::rrs_status_t status;

    // Sequencer: idle, scan, push
    rrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Slot table, search pointer and output register
    rrs_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_word  (req_word),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

endmodule

[hdl/rrs_ctrl.sv]
// Sequencer for the scheduler: accept, scan the slot table, push the result.
// Depends on rrs_pkg for command, status and state types.
`timescale 1ns / 1ps

module rrs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  rrs_pkg::rrs_status_t status,
    output rrs_pkg::rrs_cmd_t    cmd
);

    rrs_pkg::rrs_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            rrs_pkg::S_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
                if (req_valid)
                begin
                    state_next = status.direct ? rrs_pkg::S_PUSH : rrs_pkg::S_SCAN;
                end
            end
            rrs_pkg::S_SCAN:
            begin
                cmd.step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = rrs_pkg::S_PUSH;
                end
            end
            rrs_pkg::S_PUSH:
            begin
                // hold until the output register can take the word
                if (!status.out_busy)
                begin
                    cmd.push   = 1'b1;
                    state_next = rrs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rrs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[hdl/rrs_datapath.sv]
// Slot table, current slot, halt flag, scan pointer and output register.
// Depends on rrs_pkg; driven by commands from rrs_ctrl.
`timescale 1ns / 1ps

module rrs_datapath #(
    parameter int NUM_SLOTS = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rrs_pkg::req_word_t   req_word,
    input  rrs_pkg::rrs_cmd_t    cmd,
    output rrs_pkg::rrs_status_t status,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rrs_pkg::rsp_word_t   rsp_word
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);

    logic [1:0]                st_reg [NUM_SLOTS];
    logic [SW-1:0]             cur_reg;
    logic                      halted_reg;
    logic [SW-1:0]             prev_reg;
    logic [SW-1:0]             idx_reg;
    logic [SW-1:0]             cnt_reg;
    logic                      create_reg;
    logic [rrs_pkg::ADDR_W-1:0] addr_reg;
    rrs_pkg::rsp_word_t        res_reg;
    rrs_pkg::rsp_word_t        out_reg;
    logic                      out_valid_reg;

    logic          unknown_req;
    logic          hit;
    logic          last;
    logic [SW-1:0] cur_succ;
    logic [SW-1:0] idx_succ;
    logic [NUM_SLOTS-1:0] running_vec;

    function automatic logic [1:0] to_fld(input logic [SW-1:0] v);
        logic [SW+1:0] w;
        w = {2'b00, v};
        return w[1:0];
    endfunction

    assign unknown_req = (req_word.req_type != rrs_pkg::REQ_CREATE) &&
                         (req_word.req_type != rrs_pkg::REQ_YIELD) &&
                         (req_word.req_type != rrs_pkg::REQ_EXIT);

    assign cur_succ = (cur_reg == LAST_IDX) ? '0 : cur_reg + 1'b1;
    assign idx_succ = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    assign hit  = create_reg ? (st_reg[idx_reg] == rrs_pkg::ST_FREE)
                             : (st_reg[idx_reg] == rrs_pkg::ST_RUNNABLE);
    assign last = (cnt_reg == LAST_IDX);

    assign status.direct    = halted_reg || unknown_req;
    assign status.scan_done = hit || last;
    assign status.out_busy  = out_valid_reg && !rsp_ready;

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_reg;

    // Slot table and scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                st_reg[i] <= (i == 0) ? rrs_pkg::ST_RUNNING : rrs_pkg::ST_FREE;
            end
            cur_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else if (cmd.accept && !status.direct &&
                 req_word.req_type != rrs_pkg::REQ_CREATE)
        begin
            st_reg[cur_reg] <= (req_word.req_type == rrs_pkg::REQ_YIELD) ?
                               rrs_pkg::ST_RUNNABLE : rrs_pkg::ST_FREE;
        end
        else if (cmd.step)
        begin
            if (hit)
            begin
                st_reg[idx_reg] <= create_reg ? rrs_pkg::ST_RUNNABLE : rrs_pkg::ST_RUNNING;
                if (!create_reg)
                begin
                    cur_reg <= idx_reg;
                end
            end
            else if (last && !create_reg)
            begin
                halted_reg <= 1'b1;
            end
        end
    end

    // Item registers, scan pointer and result staging
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            prev_reg   <= cur_reg;
            addr_reg   <= req_word.entry_address;
            create_reg <= (req_word.req_type == rrs_pkg::REQ_CREATE);
            cnt_reg    <= '0;
            idx_reg    <= (req_word.req_type == rrs_pkg::REQ_CREATE) ? '0 : cur_succ;
            res_reg    <= '{slot:          to_fld(cur_reg),
                            prev_slot:     to_fld(cur_reg),
                            switched:      1'b0,
                            start_address: '0,
                            table_full:    1'b0,
                            no_runnable:   halted_reg};
        end
        else if (cmd.step)
        begin
            if (hit)
            begin
                res_reg <= '{slot:          to_fld(idx_reg),
                             prev_slot:     to_fld(prev_reg),
                             switched:      !create_reg && (idx_reg != prev_reg),
                             start_address: create_reg ? addr_reg : '0,
                             table_full:    1'b0,
                             no_runnable:   1'b0};
            end
            else if (last)
            begin
                res_reg <= '{slot:          to_fld(prev_reg),
                             prev_slot:     to_fld(prev_reg),
                             switched:      1'b0,
                             start_address: '0,
                             table_full:    create_reg,
                             no_runnable:   !create_reg};
            end
            else
            begin
                idx_reg <= idx_succ;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_reg <= res_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            running_vec[i] = (st_reg[i] == rrs_pkg::ST_RUNNING);
        end
    end

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(halted_reg))
        else $error("halt flag cleared");

    a_one_running: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(running_vec) <= 1)
        else $error("more than one slot running");

    a_cur_running: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && !halted_reg) |-> (st_reg[cur_reg] == rrs_pkg::ST_RUNNING))
        else $error("current slot not running at accept");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !(out_valid_reg && !rsp_ready))
        else $error("push into occupied output register");

endmodule
